FILE: sv/abms_pkg.sv
`timescale 1ns / 1ps

package abms_pkg;

  // byte lanes of one beat, also the number of memory banks
  localparam int unsigned LANES = 4;

  // entries between the front and the back
  localparam int unsigned QUEUE_DEPTH = 4;

  // beat size codes (log2 bytes)
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // one classified channel cycle, handed from the front to the back
  typedef struct packed {
    logic              addr_ready;
    logic              data_ready;
    logic              resp_valid;
    logic              read_last;
    logic              chk_oor;
    logic              rd;
    logic              wr;
    logic [1:0]        size;
    logic [31:0]       beat;
    logic [LANES-1:0]  wstrb;
    logic [31:0]       wdata;
  } cmd_t;

  function automatic logic [LANES-1:0] lane_mask(input logic [1:0] size);
    logic [LANES-1:0] m;
    case (size)
      SIZE_BYTE: m = 4'b0001;
      SIZE_HALF: m = 4'b0011;
      default:   m = 4'b1111;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/abms_ram.sv
`timescale 1ns / 1ps

module abms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/abms_front.sv
`timescale 1ns / 1ps

module abms_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             acc_i,
  input  logic                             op_i,
  input  logic                             addr_valid_i,
  input  logic [31:0]                      addr_i,
  input  logic [7:0]                       burst_len_i,
  input  logic [1:0]                       size_code_i,
  input  logic                             result_ready_i,
  input  logic                             wdata_valid_i,
  input  logic [31:0]                      wdata_i,
  input  logic [abms_pkg::LANES-1:0]       wstrb_i,
  input  logic                             wlast_i,
  output abms_pkg::cmd_t                   cmd_o
);

  typedef enum logic [1:0] {
    R_IDLE  = 2'b01,
    R_BURST = 2'b10
  } rd_state_e;

  typedef enum logic [2:0] {
    W_IDLE = 3'b001,
    W_DATA = 3'b010,
    W_RESP = 3'b100
  } wr_state_e;

  rd_state_e   rd_state_q, rd_state_d;
  logic [31:0] rd_base_q, rd_base_d;
  logic [7:0]  rd_len_q, rd_len_d;
  logic [1:0]  rd_size_q, rd_size_d;
  logic [7:0]  rd_count_q, rd_count_d;

  wr_state_e   wr_state_q, wr_state_d;
  logic [31:0] wr_base_q, wr_base_d;
  logic [1:0]  wr_size_q, wr_size_d;
  logic [8:0]  wr_count_q, wr_count_d;

  logic [1:0]  size_c;
  logic [9:0]  rd_ofs;
  logic [10:0] wr_ofs;
  logic [31:0] rd_beat;
  logic [31:0] wr_beat;

  // size code three behaves as a word
  assign size_c  = (size_code_i > abms_pkg::SIZE_WORD) ? abms_pkg::SIZE_WORD : size_code_i;
  assign rd_ofs  = 10'(rd_count_q) << rd_size_q;
  assign wr_ofs  = 11'(wr_count_q) << wr_size_q;
  assign rd_beat = rd_base_q + 32'(rd_ofs);
  assign wr_beat = wr_base_q + 32'(wr_ofs);

  always_comb begin
    rd_state_d = rd_state_q;
    rd_base_d  = rd_base_q;
    rd_len_d   = rd_len_q;
    rd_size_d  = rd_size_q;
    rd_count_d = rd_count_q;
    wr_state_d = wr_state_q;
    wr_base_d  = wr_base_q;
    wr_size_d  = wr_size_q;
    wr_count_d = wr_count_q;

    cmd_o       = '0;
    cmd_o.wdata = wdata_i;
    cmd_o.wstrb = wstrb_i;

    if (!op_i) begin
      case (rd_state_q)
        R_BURST: begin
          cmd_o.resp_valid = 1'b1;
          cmd_o.read_last  = (rd_count_q == rd_len_q);
          cmd_o.rd         = 1'b1;
          cmd_o.chk_oor    = 1'b1;
          cmd_o.beat       = rd_beat;
          cmd_o.size       = rd_size_q;
          if (result_ready_i) begin
            rd_count_d = rd_count_q + 8'd1;
            if (rd_count_q == rd_len_q) begin
              rd_state_d = R_IDLE;
            end
          end
        end
        default: begin
          cmd_o.addr_ready = 1'b1;
          rd_count_d       = '0;
          if (addr_valid_i) begin
            rd_base_d  = addr_i;
            rd_len_d   = burst_len_i;
            rd_size_d  = size_c;
            rd_state_d = R_BURST;
          end
        end
      endcase
    end else begin
      case (wr_state_q)
        W_DATA: begin
          cmd_o.data_ready = 1'b1;
          cmd_o.chk_oor    = 1'b1;
          cmd_o.wr         = wdata_valid_i;
          cmd_o.beat       = wr_beat;
          cmd_o.size       = wr_size_q;
          if (wdata_valid_i) begin
            wr_count_d = wr_count_q + 9'd1;
            if (wlast_i) begin
              wr_state_d = W_RESP;
            end
          end
        end
        W_RESP: begin
          cmd_o.resp_valid = 1'b1;
          if (result_ready_i) begin
            wr_state_d = W_IDLE;
          end
        end
        default: begin
          cmd_o.addr_ready = 1'b1;
          wr_count_d       = '0;
          wr_state_d       = W_IDLE;
          if (addr_valid_i) begin
            wr_base_d  = addr_i;
            wr_size_d  = size_c;
            wr_state_d = W_DATA;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_state_q <= R_IDLE;
      rd_base_q  <= '0;
      rd_len_q   <= '0;
      rd_size_q  <= '0;
      rd_count_q <= '0;
      wr_state_q <= W_IDLE;
      wr_base_q  <= '0;
      wr_size_q  <= '0;
      wr_count_q <= '0;
    end else if (acc_i) begin
      rd_state_q <= rd_state_d;
      rd_base_q  <= rd_base_d;
      rd_len_q   <= rd_len_d;
      rd_size_q  <= rd_size_d;
      rd_count_q <= rd_count_d;
      wr_state_q <= wr_state_d;
      wr_base_q  <= wr_base_d;
      wr_size_q  <= wr_size_d;
      wr_count_q <= wr_count_d;
    end
  end

endmodule

FILE: sv/abms_queue.sv
`timescale 1ns / 1ps

module abms_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  abms_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output abms_pkg::cmd_t data_o
);

  localparam int unsigned PTR_W = $clog2(abms_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(abms_pkg::QUEUE_DEPTH + 1);

  abms_pkg::cmd_t   mem_q [abms_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(abms_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/abms_back.sv
`timescale 1ns / 1ps

module abms_back #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    memory_base_i,
  input  logic           q_valid_i,
  input  abms_pkg::cmd_t cmd_i,
  output logic           pop_o,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic           addr_ready_o,
  output logic           data_ready_o,
  output logic           resp_valid_o,
  output logic           read_last_o,
  output logic [31:0]    read_data_o,
  output logic           out_of_range_o
);

  localparam int unsigned LANES = abms_pkg::LANES;
  localparam int unsigned ROWS  = (MEM_BYTES + LANES - 1) / LANES;
  localparam int unsigned ROW_W = $clog2(ROWS);

  typedef struct packed {
    logic             addr_ready;
    logic             data_ready;
    logic             resp_valid;
    logic             read_last;
    logic             oor;
    logic [LANES-1:0] rd_mask;
    logic [1:0]       rot;
  } meta_t;

  logic [31:0]      lane_addr [LANES];
  logic [32:0]      diff      [LANES];
  logic [7:0]       wbyte     [LANES];
  logic [LANES-1:0] in_win;
  logic [LANES-1:0] size_mask;
  logic [LANES-1:0] rd_mask;
  logic [LANES-1:0] wr_mask;

  logic [1:0]       bank_lane  [LANES];
  logic [ROW_W-1:0] bank_addr  [LANES];
  logic [7:0]       bank_wdata [LANES];
  logic [7:0]       bank_rdata [LANES];
  logic [LANES-1:0] bank_we;
  logic [LANES-1:0] bank_re;

  logic  en;
  meta_t meta;
  meta_t a_meta_q;
  logic  a_valid_q;
  logic  out_valid_q;
  logic  [31:0] rdata;

  // per byte window check, bytes may cross the window edge or wrap at 2^32
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_addr[i] = cmd_i.beat + 32'(i);
      diff[i]      = {1'b0, lane_addr[i]} - {1'b0, memory_base_i};
      in_win[i]    = !diff[i][32] && (diff[i][31:0] < 32'(MEM_BYTES));
      wbyte[i]     = cmd_i.wdata[8*i +: 8];
    end
  end

  assign size_mask = abms_pkg::lane_mask(cmd_i.size);
  assign rd_mask   = {LANES{cmd_i.rd & in_win[0]}} & in_win & size_mask;
  assign wr_mask   = {LANES{cmd_i.wr}} & cmd_i.wstrb & in_win & size_mask;

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && q_valid_i;

  // byte offsets of a beat are consecutive modulo four, so every lane lands in its own bank
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      bank_lane[b]  = 2'(b) - diff[0][1:0];
      bank_addr[b]  = diff[bank_lane[b]][ROW_W+1:2];
      bank_wdata[b] = wbyte[bank_lane[b]];
      bank_we[b]    = pop_o && wr_mask[bank_lane[b]];
      bank_re[b]    = pop_o && rd_mask[bank_lane[b]];
    end
  end

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    abms_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .re_i    (bank_re[b]),
      .addr_i  (bank_addr[b]),
      .wdata_i (bank_wdata[b]),
      .rdata_o (bank_rdata[b])
    );
  end

  always_comb begin
    meta.addr_ready = cmd_i.addr_ready;
    meta.data_ready = cmd_i.data_ready;
    meta.resp_valid = cmd_i.resp_valid;
    meta.read_last  = cmd_i.read_last;
    meta.oor        = cmd_i.chk_oor & !in_win[0];
    meta.rd_mask    = rd_mask;
    meta.rot        = diff[0][1:0];
  end

  // bytes past the window or outside the beat read as zero
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rdata[8*i +: 8] = a_meta_q.rd_mask[i] ? bank_rdata[2'(a_meta_q.rot + 2'(i))] : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= q_valid_i;
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_meta_q <= meta;
    end
    if (en && a_valid_q) begin
      addr_ready_o   <= a_meta_q.addr_ready;
      data_ready_o   <= a_meta_q.data_ready;
      resp_valid_o   <= a_meta_q.resp_valid;
      read_last_o    <= a_meta_q.read_last;
      out_of_range_o <= a_meta_q.oor;
      read_data_o    <= rdata;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/axi_burst_memory_slave.sv
`timescale 1ns / 1ps

// byte-addressed memory slave behind an axi-like incrementing burst interface. every input
// transfer is one cycle of the read channel (op 0) or the write channel (op 1) and yields
// exactly one output transfer carrying that cycle's handshake outputs, read beat and
// out-of-range flag. the memory window is [memory_base, memory_base + MEM_BYTES), with no wrap
// past 2^32, and is held as four byte-wide banks so any beat, aligned or not, is read or
// written in one memory access. beats outside the window read as zero and their writes are
// dropped; bytes never written read back undefined. the front decodes each transfer against
// the read and write burst state and queues it; the back performs the bank access and
// presents the result from an output register. sustained rate is one transfer per clock
// while the output is not stalled; an accepted transfer passes through the queue, the
// registered bank read and the output register in that order. input stall is raised
// only when the four-entry queue between front and back is full, i.e. when the output side
// has been stalled. the memory needs no clearing pass after reset. memory_base is written
// through its own valid/ready port, which is always ready; the user must write it only while
// no transfer is in flight, the block itself does not enforce this.
module axi_burst_memory_slave #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_memory_base_i,

  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic        addr_valid_i,
  input  logic [31:0] addr_i,
  input  logic [7:0]  burst_len_i,
  input  logic [1:0]  size_code_i,
  input  logic        result_ready_i,
  input  logic        wdata_valid_i,
  input  logic [31:0] wdata_i,
  input  logic [3:0]  wstrb_i,
  input  logic        wlast_i,

  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        addr_ready_o,
  output logic        data_ready_o,
  output logic        resp_valid_o,
  output logic        read_last_o,
  output logic [31:0] read_data_o,
  output logic        out_of_range_o
);

  logic [31:0]    base_q;
  logic           acc;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  abms_pkg::cmd_t cmd_in;
  abms_pkg::cmd_t cmd_out;

  // window base register, write transfers are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_valid_i) begin
      base_q <= cfg_memory_base_i;
    end
  end

  // a transfer is taken whenever the queue has room
  assign in_stall_o = q_full;
  assign acc        = in_valid_i && !q_full;

  // front: burst bookkeeping and beat address per channel
  abms_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (acc),
    .op_i           (op_i),
    .addr_valid_i   (addr_valid_i),
    .addr_i         (addr_i),
    .burst_len_i    (burst_len_i),
    .size_code_i    (size_code_i),
    .result_ready_i (result_ready_i),
    .wdata_valid_i  (wdata_valid_i),
    .wdata_i        (wdata_i),
    .wstrb_i        (wstrb_i),
    .wlast_i        (wlast_i),
    .cmd_o          (cmd_in)
  );

  // decouples front and back so an output stall does not stop decoding at once
  abms_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (cmd_out)
  );

  // back: window check, bank access and result register
  abms_back #(
    .MEM_BYTES (MEM_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .memory_base_i  (base_q),
    .q_valid_i      (q_valid),
    .cmd_i          (cmd_out),
    .pop_o          (q_pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .addr_ready_o   (addr_ready_o),
    .data_ready_o   (data_ready_o),
    .resp_valid_o   (resp_valid_o),
    .read_last_o    (read_last_o),
    .read_data_o    (read_data_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

FILE: sv/abms_checker.sv
`timescale 1ns / 1ps

module abms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        addr_ready_o,
  input logic        data_ready_o,
  input logic        resp_valid_o,
  input logic        read_last_o,
  input logic [31:0] read_data_o,
  input logic        out_of_range_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("stalled result changed");

  // every valid result is exactly one of address phase, data phase or response
  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({addr_ready_o, data_ready_o, resp_valid_o}))
    else $error("result shows no single channel phase");

  // read beat content only comes with a valid beat
  a_read_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_last_o || (read_data_o != 32'h0)) |-> resp_valid_o)
    else $error("read beat fields without valid beat");

  // range flag never comes with an address phase
  a_oor_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> !addr_ready_o)
    else $error("range flag in address phase");

endmodule

bind axi_burst_memory_slave abms_checker u_abms_checker (.*);
